// ===== src/glrs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register codes and types for the guide line row span block.
package glrs_pkg;

   localparam int SCREEN_WIDTH  = 800;
   localparam int SCREEN_HEIGHT = 480;

   localparam int COORD_W    = 12;
   localparam int ROW_W      = 9;
   localparam int MAG_W      = 12;
   localparam int PROD_W     = 24;
   localparam int SUM_W      = 25;
   localparam int TRIPLE_W   = 27;
   localparam int CX_W       = 14;
   localparam int SPAN_W     = 10;
   localparam int COLOR_W    = 24;
   localparam int HW_W       = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 48;

   localparam int QUO_W      = 12;
   localparam int DIV_STEP   = 2;
   localparam int DIV_STAGES = QUO_W / DIV_STEP;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_COLOR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_COLOR  = 2'd3;

   localparam logic [HW_W-1:0]    HALF_WIDTH_RESET = 6'd10;
   localparam logic [COLOR_W-1:0] NEAR_COLOR_RESET = 24'hFF0000;
   localparam logic [COLOR_W-1:0] MID_COLOR_RESET  = 24'hFFFF00;
   localparam logic [COLOR_W-1:0] FAR_COLOR_RESET  = 24'h00FF00;

   typedef struct packed {
      logic [PROD_W-1:0] num;
      logic [MAG_W-1:0]  den;
   } div_in_type;

   typedef struct packed {
      logic                      valid;
      logic                      ok;
      logic                      neg;
      logic signed [COORD_W-1:0] x0;
      logic [PROD_W-1:0]         tsq;
      logic [SUM_W-1:0]          seg_sum;
   } div_side_type;

endpackage

// ===== src/glrs_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider for magnitudes, two quotient bits per stage.
module glrs_div (
   input  logic                       clock,
   input  logic                       advance,
   input  glrs_pkg::div_in_type       div_in,
   output logic [glrs_pkg::QUO_W-1:0] quo_out
);
   import glrs_pkg::*;

   logic [PROD_W-1:0] rem_ff [DIV_STAGES];
   logic [PROD_W-1:0] rem_in [DIV_STAGES];
   logic [MAG_W-1:0]  den_ff [DIV_STAGES];
   logic [MAG_W-1:0]  den_in [DIV_STAGES];
   logic [QUO_W-1:0]  quo_ff [DIV_STAGES];
   logic [QUO_W-1:0]  quo_in [DIV_STAGES];

   always_comb begin
      logic [PROD_W-1:0] r;
      logic [PROD_W-1:0] trial;
      logic [MAG_W-1:0]  d;
      logic [QUO_W-1:0]  q;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            r = div_in.num;
            d = div_in.den;
            q = '0;
         end else begin
            r = rem_ff[s-1];
            d = den_ff[s-1];
            q = quo_ff[s-1];
         end
         for (int k = 0; k < DIV_STEP; k++) begin
            trial = PROD_W'(d) << (QUO_W - 1 - s * DIV_STEP - k);
            if (r >= trial) begin
               r = r - trial;
               q = {q[QUO_W-2:0], 1'b1};
            end else begin
               q = {q[QUO_W-2:0], 1'b0};
            end
         end
         rem_in[s] = r;
         den_in[s] = d;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quo_out = quo_ff[DIV_STAGES-1];

endmodule

// ===== src/guide_line_row_span.sv =====
`timescale 1ns / 1ps
// Top level of the guide line row span block: row span and color of a thick guide line.
//
// One beat in gives one beat out. The block takes a new beat every clock while
// the output register is empty or being taken; each beat passes through stages
// s1 to s3, the six-stage restoring divider that finds the line center, two
// quotient bits per stage, then stages sa and sb and the output register. All
// stages advance together whenever the output register is empty or being taken,
// so a stall on the result side holds every stage. Configuration writes complete
// in the cycle they are presented and should be made while no beat is in flight.
module guide_line_row_span (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], row[56:48], zero pad.
   input  logic [glrs_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // span_left[9:0], span_right[19:10], span_color[43:20], zero pad.
   output logic [glrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // drawn.
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [glrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [glrs_pkg::COLOR_W-1:0]    csr_data
);
   import glrs_pkg::*;

   localparam logic signed [CX_W-1:0] CX_SCREEN_W  = CX_W'(SCREEN_WIDTH);
   localparam logic [SPAN_W:0]        SPAN_LAST    = (SPAN_W + 1)'(SCREEN_WIDTH - 1);
   localparam logic [ROW_W:0]         ROW_SCREEN_H = (ROW_W + 1)'(SCREEN_HEIGHT);

   logic                 advance;
   logic [HW_W-1:0]      half_width_ff;
   logic [COLOR_W-1:0]   near_color_ff;
   logic [COLOR_W-1:0]   mid_color_ff;
   logic [COLOR_W-1:0]   far_color_ff;

   logic signed [COORD_W:0] x0_e, y0_e, x1_e, y1_e, row_e;
   logic [ROW_W-1:0]        row_in;
   logic                    ok_in, neg_in;
   logic [MAG_W-1:0]        adx_in, ady_in, at_in;

   logic                      s1_valid_ff, s1_ok_ff, s1_neg_ff;
   logic signed [COORD_W-1:0] s1_x0_ff;
   logic [MAG_W-1:0]          s1_adx_ff, s1_ady_ff, s1_at_ff;

   logic                      s2_valid_ff, s2_ok_ff, s2_neg_ff;
   logic signed [COORD_W-1:0] s2_x0_ff;
   logic [MAG_W-1:0]          s2_ady_ff;
   logic [PROD_W-1:0]         s2_num_ff, s2_dxsq_ff, s2_dysq_ff, s2_tsq_ff;

   logic                      s3_valid_ff, s3_ok_ff, s3_neg_ff;
   logic signed [COORD_W-1:0] s3_x0_ff;
   logic [MAG_W-1:0]          s3_ady_ff;
   logic [PROD_W-1:0]         s3_num_ff, s3_tsq_ff;
   logic [SUM_W-1:0]          s3_seg_ff;

   div_in_type              div_in;
   logic [QUO_W-1:0]        quo;
   div_side_type            side_ff [DIV_STAGES];
   div_side_type            side_out;
   logic signed [CX_W-1:0]  x0_wide, quo_wide;

   logic                   sa_valid_ff, sa_ok_ff;
   logic signed [CX_W-1:0] sa_cx_ff;
   logic [PROD_W-1:0]      sa_qsq_ff, sa_tsq_ff;
   logic [SUM_W-1:0]       sa_seg_ff;

   logic                   sb_valid_ff, sb_ok_ff;
   logic signed [CX_W-1:0] sb_cx_ff;
   logic [SUM_W-1:0]       sb_dist_ff, sb_seg_ff;

   logic                 drawn_in;
   logic [SPAN_W-1:0]    cx_col, hw_ext, left_in, right_in;
   logic [SPAN_W:0]      right_sum;
   logic [TRIPLE_W-1:0]  tri_full, tri_half, seg_ext;
   logic [COLOR_W-1:0]   color_in;

   logic                 rsp_valid_ff, rsp_drawn_ff;
   logic [SPAN_W-1:0]    rsp_left_ff, rsp_right_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= HALF_WIDTH_RESET;
         near_color_ff <= NEAR_COLOR_RESET;
         mid_color_ff  <= MID_COLOR_RESET;
         far_color_ff  <= FAR_COLOR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_WIDTH: half_width_ff <= csr_data[HW_W-1:0];
            CSR_NEAR_COLOR: near_color_ff <= csr_data;
            CSR_MID_COLOR:  mid_color_ff  <= csr_data;
            CSR_FAR_COLOR:  far_color_ff  <= csr_data;
         endcase
      end
   end

   assign x0_e   = {req_tdata[11], req_tdata[11:0]};
   assign y0_e   = {req_tdata[23], req_tdata[23:12]};
   assign x1_e   = {req_tdata[35], req_tdata[35:24]};
   assign y1_e   = {req_tdata[47], req_tdata[47:36]};
   assign row_in = req_tdata[56:48];
   assign row_e  = $signed({4'b0000, row_in});

   assign ok_in  = (y0_e != y1_e) && ((row_e >= y0_e) || (row_e >= y1_e))
                   && ((row_e <= y0_e) || (row_e <= y1_e))
                   && ({1'b0, row_in} < ROW_SCREEN_H);
   assign neg_in = (x1_e < x0_e) ^ (y1_e < y0_e) ^ (row_e < y0_e);
   assign adx_in = (x1_e >= x0_e) ? MAG_W'(x1_e - x0_e) : MAG_W'(x0_e - x1_e);
   assign ady_in = (y1_e >= y0_e) ? MAG_W'(y1_e - y0_e) : MAG_W'(y0_e - y1_e);
   assign at_in  = (row_e >= y0_e) ? MAG_W'(row_e - y0_e) : MAG_W'(y0_e - row_e);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ok_ff   <= ok_in;
         s1_neg_ff  <= neg_in;
         s1_x0_ff   <= x0_e[COORD_W-1:0];
         s1_adx_ff  <= adx_in;
         s1_ady_ff  <= ady_in;
         s1_at_ff   <= at_in;

         s2_ok_ff   <= s1_ok_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_x0_ff   <= s1_x0_ff;
         s2_ady_ff  <= s1_ady_ff;
         s2_num_ff  <= PROD_W'(s1_adx_ff) * PROD_W'(s1_at_ff);
         s2_dxsq_ff <= PROD_W'(s1_adx_ff) * PROD_W'(s1_adx_ff);
         s2_dysq_ff <= PROD_W'(s1_ady_ff) * PROD_W'(s1_ady_ff);
         s2_tsq_ff  <= PROD_W'(s1_at_ff) * PROD_W'(s1_at_ff);

         s3_ok_ff   <= s2_ok_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_x0_ff   <= s2_x0_ff;
         s3_ady_ff  <= s2_ady_ff;
         s3_num_ff  <= s2_num_ff;
         s3_tsq_ff  <= s2_tsq_ff;
         s3_seg_ff  <= SUM_W'(s2_dxsq_ff) + SUM_W'(s2_dysq_ff);
      end
   end

   assign div_in.num = s3_num_ff;
   assign div_in.den = s3_ady_ff;

   glrs_div u_div (
      .clock   (clock),
      .advance (advance),
      .div_in  (div_in),
      .quo_out (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         side_ff[0].valid <= s3_valid_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_ff[i].valid <= side_ff[i-1].valid;
         end
      end
      if (advance) begin
         side_ff[0].ok      <= s3_ok_ff;
         side_ff[0].neg     <= s3_neg_ff;
         side_ff[0].x0      <= s3_x0_ff;
         side_ff[0].tsq     <= s3_tsq_ff;
         side_ff[0].seg_sum <= s3_seg_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_ff[i].ok      <= side_ff[i-1].ok;
            side_ff[i].neg     <= side_ff[i-1].neg;
            side_ff[i].x0      <= side_ff[i-1].x0;
            side_ff[i].tsq     <= side_ff[i-1].tsq;
            side_ff[i].seg_sum <= side_ff[i-1].seg_sum;
         end
      end
   end

   assign side_out = side_ff[DIV_STAGES-1];
   assign x0_wide  = CX_W'(side_out.x0);
   assign quo_wide = $signed(CX_W'(quo));

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
         sb_valid_ff <= 1'b0;
      end else if (advance) begin
         sa_valid_ff <= side_out.valid;
         sb_valid_ff <= sa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sa_ok_ff   <= side_out.ok;
         sa_cx_ff   <= side_out.neg ? x0_wide - quo_wide : x0_wide + quo_wide;
         sa_qsq_ff  <= PROD_W'(quo) * PROD_W'(quo);
         sa_tsq_ff  <= side_out.tsq;
         sa_seg_ff  <= side_out.seg_sum;

         sb_ok_ff   <= sa_ok_ff;
         sb_cx_ff   <= sa_cx_ff;
         sb_dist_ff <= SUM_W'(sa_qsq_ff) + SUM_W'(sa_tsq_ff);
         sb_seg_ff  <= sa_seg_ff;
      end
   end

   // With S the sum of squares: dist < S/3 exactly when 3*dist + 3 <= S, and
   // dist < 2*(S/3) exactly when 3*(dist/2) + 3 <= S, all divisions truncating.
   always_comb begin
      drawn_in  = sb_ok_ff && !sb_cx_ff[CX_W-1] && (sb_cx_ff < CX_SCREEN_W);
      cx_col    = sb_cx_ff[SPAN_W-1:0];
      hw_ext    = SPAN_W'(half_width_ff);
      left_in   = (cx_col < hw_ext) ? '0 : cx_col - hw_ext;
      right_sum = (SPAN_W + 1)'(cx_col) + (SPAN_W + 1)'(half_width_ff);
      right_in  = (right_sum > SPAN_LAST) ? SPAN_LAST[SPAN_W-1:0] : right_sum[SPAN_W-1:0];
      tri_full  = TRIPLE_W'(sb_dist_ff) + TRIPLE_W'({sb_dist_ff, 1'b0}) + TRIPLE_W'(3);
      tri_half  = TRIPLE_W'(sb_dist_ff[SUM_W-1:1]) + TRIPLE_W'({sb_dist_ff[SUM_W-1:1], 1'b0})
                  + TRIPLE_W'(3);
      seg_ext   = TRIPLE_W'(sb_seg_ff);
      priority if (tri_full <= seg_ext) begin
         color_in = near_color_ff;
      end else if (tri_half <= seg_ext) begin
         color_in = mid_color_ff;
      end else begin
         color_in = far_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_drawn_ff <= drawn_in;
         rsp_left_ff  <= drawn_in ? left_in : '0;
         rsp_right_ff <= drawn_in ? right_in : '0;
         rsp_color_ff <= drawn_in ? color_in : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_drawn_ff;
   assign rsp_tdata  = {(RSP_DATA_W - COLOR_W - 2 * SPAN_W)'(0),
                        rsp_color_ff, rsp_right_ff, rsp_left_ff};

`ifndef ASSERT_OFF
   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_drawn_ff |-> rsp_left_ff <= rsp_right_ff)
      else $error("Span left edge lies right of the right edge.");

   a_span_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_drawn_ff |-> rsp_right_ff <= SPAN_LAST[SPAN_W-1:0])
      else $error("Span reaches past the last screen column.");

   a_span_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_drawn_ff
      |-> (rsp_right_ff - rsp_left_ff) <= SPAN_W'({half_width_ff, 1'b0}))
      else $error("Span is wider than twice the half width.");

   a_blank_when_hidden: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_drawn_ff
      |-> rsp_left_ff == '0 && rsp_right_ff == '0 && rsp_color_ff == '0)
      else $error("A row that is not drawn carries a nonzero span.");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the guide line row span block: random and directed line rows.
module tb;
   import glrs_pkg::*;

   typedef struct packed {
      logic [ROW_W-1:0]          row;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_x;
   } line_req_type;

   typedef struct packed {
      logic               drawn;
      logic [COLOR_W-1:0] color;
      logic [SPAN_W-1:0]  right;
      logic [SPAN_W-1:0]  left;
   } span_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [COLOR_W-1:0]    csr_data = '0;

   logic [HW_W-1:0]    cfg_half_width = HALF_WIDTH_RESET;
   logic [COLOR_W-1:0] cfg_near_color = NEAR_COLOR_RESET;
   logic [COLOR_W-1:0] cfg_mid_color  = MID_COLOR_RESET;
   logic [COLOR_W-1:0] cfg_far_color  = FAR_COLOR_RESET;

   line_req_type pending_lines[$];
   span_type     expected_spans[$];
   line_req_type req_item = '0;
   logic         req_taken = 1'b0;
   int           req_idle_pct = 8;
   int           rsp_idle_pct = 54;
   int           error_count = 0;
   int           rows_checked = 0;
   int           rows_drawn = 0;
   int           settings_used = 1;

   guide_line_row_span dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: errors");
      $finish;
   end

   function automatic span_type predict_span(line_req_type ln);
      span_type s;
      longint   x0, y0, x1, y1, y, dx, dy, ylo, yhi, cx, dist_sq, seg, lft, rgt;
      s = '0;
      x0 = ln.start_x;
      y0 = ln.start_y;
      x1 = ln.end_x;
      y1 = ln.end_y;
      y = ln.row;
      dx = x1 - x0;
      dy = y1 - y0;
      ylo = (y0 < y1) ? y0 : y1;
      yhi = (y0 > y1) ? y0 : y1;
      if (dy == 0 || y < ylo || y > yhi || y >= SCREEN_HEIGHT) return s;
      cx = x0 + (dx * (y - y0)) / dy;
      if (cx < 0 || cx >= SCREEN_WIDTH) return s;
      seg = (dx * dx + dy * dy) / 3;
      dist_sq = (cx - x0) * (cx - x0) + (y - y0) * (y - y0);
      if (dist_sq < seg) begin
         s.color = cfg_near_color;
      end else if (dist_sq < 2 * seg) begin
         s.color = cfg_mid_color;
      end else begin
         s.color = cfg_far_color;
      end
      lft = cx - longint'(cfg_half_width);
      if (lft < 0) lft = 0;
      rgt = cx + longint'(cfg_half_width);
      if (rgt > SCREEN_WIDTH - 1) rgt = SCREEN_WIDTH - 1;
      s.drawn = 1'b1;
      s.left = SPAN_W'(lft);
      s.right = SPAN_W'(rgt);
      return s;
   endfunction

   // Mostly lines that cross the row near the screen, the rest raw noise.
   function automatic line_req_type make_random_line();
      line_req_type ln;
      logic [63:0]  raw;
      int           r, ya, yb, xc, xa, xb, t, tmp;
      if ($urandom_range(99) < 25) begin
         raw = {$urandom, $urandom};
         ln = raw[56:0];
         return ln;
      end
      r = ($urandom_range(15) == 0) ? int'($urandom_range(511, 480)) : int'($urandom_range(479));
      ya = r - int'(($urandom_range(3) == 0) ? $urandom_range(1500) : $urandom_range(40));
      yb = r + int'(($urandom_range(3) == 0) ? $urandom_range(1500) : $urandom_range(40));
      t = $urandom_range(19);
      if (t == 0) begin
         ya = r;
         yb = r;
      end else if (t == 1) begin
         ya = r + 1 + int'($urandom_range(30));
         yb = ya + int'($urandom_range(30));
      end else if (t == 2) begin
         yb = r - 1 - int'($urandom_range(30));
         ya = yb - int'($urandom_range(30));
      end
      if ($urandom_range(1)) begin
         tmp = ya;
         ya = yb;
         yb = tmp;
      end
      xc = int'($urandom_range(1000)) - 100;
      xa = xc + int'($urandom_range(600)) - 300;
      xb = xc + int'($urandom_range(600)) - 300;
      ln.start_x = xa[11:0];
      ln.start_y = ya[11:0];
      ln.end_x = xb[11:0];
      ln.end_y = yb[11:0];
      ln.row = r[8:0];
      return ln;
   endfunction

   task automatic add_line(input int x0, input int y0, input int x1, input int y1, input int r);
      line_req_type ln;
      ln.start_x = x0[11:0];
      ln.start_y = y0[11:0];
      ln.end_x = x1[11:0];
      ln.end_y = y1[11:0];
      ln.row = r[8:0];
      pending_lines.push_back(ln);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Returns at a rising edge once the pipe is empty and the last result has left.
   task automatic wait_for_idle();
      while (pending_lines.size() != 0 || req_tvalid || expected_spans.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   always @(negedge clock) begin : driver
      line_req_type next_line;
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_lines.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               next_line = pending_lines.pop_front();
               req_item <= next_line;
               req_tdata <= {7'b0, next_line};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      span_type got, want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HALF_WIDTH: cfg_half_width = csr_data[HW_W-1:0];
               CSR_NEAR_COLOR: cfg_near_color = csr_data;
               CSR_MID_COLOR:  cfg_mid_color = csr_data;
               CSR_FAR_COLOR:  cfg_far_color = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_spans.push_back(predict_span(req_item));
         if (rsp_tvalid && rsp_tready) begin
            got.drawn = rsp_tuser;
            got.left = rsp_tdata[9:0];
            got.right = rsp_tdata[19:10];
            got.color = rsp_tdata[43:20];
            if (expected_spans.size() == 0) begin
               error_count++;
               $display("%0t: result beat with none expected, drawn=%0b left=%0d right=%0d color=%06h",
                        $time, got.drawn, got.left, got.right, got.color);
            end else begin
               want = expected_spans.pop_front();
               rows_checked++;
               if (want.drawn) rows_drawn++;
               if (got !== want) begin
                  error_count++;
                  $display("%0t: expected drawn=%0b left=%0d right=%0d color=%06h, got drawn=%0b left=%0d right=%0d color=%06h",
                           $time, want.drawn, want.left, want.right, want.color,
                           got.drawn, got.left, got.right, got.color);
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [HW_W-1:0]    hw;
      logic [COLOR_W-1:0] near_c, mid_c, far_c;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_line(100, 50, 300, 50, 50);
      add_line(100, 50, 300, 150, 49);
      add_line(100, 50, 300, 150, 151);
      add_line(100, 50, 300, 150, 150);
      add_line(100, 50, 300, 150, 50);
      add_line(400, 0, 400, 300, 0);
      add_line(400, 0, 400, 300, 173);
      add_line(400, 0, 400, 300, 174);
      add_line(400, 0, 400, 300, 244);
      add_line(400, 0, 400, 300, 245);
      add_line(400, 0, 400, 300, 300);
      add_line(10, 0, 0, 3, 1);
      add_line(0, 3, 20, 0, 1);
      add_line(-1, 0, -1, 100, 10);
      add_line(0, 0, 0, 100, 10);
      add_line(799, 0, 799, 100, 10);
      add_line(800, 0, 800, 100, 10);
      add_line(100, 0, 100, 2047, 479);
      add_line(100, 0, 100, 2047, 480);
      add_line(100, 0, 100, 2047, 511);
      add_line(-2048, -2048, 2047, 2047, 0);
      add_line(2047, -2048, -2048, 2047, 100);
      add_line(2047, 2047, -2048, -2048, 400);
      add_line(1000, -2048, -1000, 2047, 255);
      wait_for_idle();

      for (int phase = 0; phase < 6; phase++) begin
         req_idle_pct = (phase < 2) ? 8 : (phase < 4) ? 54 : 0;
         rsp_idle_pct = (phase < 2) ? 54 : (phase < 4) ? 8 : 0;
         hw = (phase == 0) ? 6'd0 : (phase == 1) ? 6'd63 : HW_W'($urandom_range(63));
         near_c = (phase == 0) ? 24'h000000 : (phase == 1) ? 24'hFFFFFF : COLOR_W'($urandom);
         mid_c = (phase == 0) ? 24'hFFFFFF : (phase == 1) ? 24'h000000 : COLOR_W'($urandom);
         far_c = (phase == 1) ? 24'h000000 : (phase == 2) ? 24'hFFFFFF : COLOR_W'($urandom);
         write_reg(CSR_HALF_WIDTH, {{(COLOR_W-HW_W){1'b0}}, hw});
         write_reg(CSR_NEAR_COLOR, near_c);
         write_reg(CSR_MID_COLOR, mid_c);
         write_reg(CSR_FAR_COLOR, far_c);
         @(negedge clock);
         csr_valid <= 1'b0;
         @(posedge clock);
         settings_used++;
         // Two batches per setting, with a full drain of the pipe between them.
         for (int batch = 0; batch < 2; batch++) begin
            for (int n = 0; n < 83; n++) pending_lines.push_back(make_random_line());
            wait_for_idle();
         end
      end

      $display("summary: %0d line rows checked, %0d of them drawn, under %0d register settings",
               rows_checked, rows_drawn, settings_used);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
